[src/c2ea_pkg.sv]
// shared types, constants and the cordic step function for the vector-to-angles block
package c2ea_pkg;

   localparam int DW = 60;
   localparam int AW = 37;

   localparam logic signed [63:0] PI_Q32   = 64'sd13493037705;
   localparam logic signed [31:0] GAIN_Q30 = 32'sd1768195363;

   localparam logic signed [63:0] ATAN_TAB [11] = '{
      64'sd3373259426, 64'sd1991351318, 64'sd1052175346, 64'sd534100635,
      64'sd268086748, 64'sd134174063, 64'sd67103403, 64'sd33553749,
      64'sd16777131, 64'sd8388597, 64'sd4194303
   };

   typedef struct packed {
      logic signed [DW-1:0] x;
      logic signed [DW-1:0] y;
      logic signed [AW-1:0] a;
   } cord_type;

   function automatic logic signed [AW-1:0] atan_step(input int i);
      logic signed [63:0] v;
      if (i < 11) begin
         v = ATAN_TAB[i];
      end else begin
         v = 64'sd1 <<< (32 - i);
      end
      return AW'(v);
   endfunction

   function automatic cord_type cordic_step(input cord_type c, input int i);
      cord_type r;
      logic signed [DW-1:0] dx;
      logic signed [DW-1:0] dy;
      dx = c.y >>> i;
      dy = c.x >>> i;
      if (c.y >= 0) begin
         r.x = c.x + dx;
         r.y = c.y - dy;
         r.a = c.a + atan_step(i);
      end else begin
         r.x = c.x - dx;
         r.y = c.y + dy;
         r.a = c.a - atan_step(i);
      end
      return r;
   endfunction

endpackage

[src/cartesian_to_euler_angles.sv]
// pipelined cordic conversion of a cartesian vector to azimuth and polar angles
// Takes one vector per cycle whenever start is high; busy never rises. Each result
// passes through two back-to-back vectoring cordic chains of one iteration per stage
// plus input, gain multiply, pre-rotation and rounding stages. rsp_valid marks each
// result for one cycle; the receiver must take it then. A zero vector gives rsp_invalid
// with zero angles.
module cartesian_to_euler_angles #(
   parameter int IN_WIDTH     = 24,
   parameter int ANGLE_FRAC   = 16,
   parameter int CORDIC_STEPS = 18
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         start,
   output logic                         busy,
   input  logic signed [IN_WIDTH-1:0]   req_vec_x,
   input  logic signed [IN_WIDTH-1:0]   req_vec_y,
   input  logic signed [IN_WIDTH-1:0]   req_vec_z,
   output logic                         rsp_valid,
   output logic signed [ANGLE_FRAC+2:0] rsp_azimuth,
   output logic        [ANGLE_FRAC+1:0] rsp_polar,
   output logic                         rsp_invalid
);

   localparam int DW  = c2ea_pkg::DW;
   localparam int AW  = c2ea_pkg::AW;
   localparam int N   = CORDIC_STEPS;
   localparam int SH  = 56 - IN_WIDTH;
   localparam int PW  = IN_WIDTH + 32;
   localparam int LAT = 2 * N + 4;
   localparam logic signed [AW-1:0] PI_A = AW'(c2ea_pkg::PI_Q32);
   localparam logic signed [AW-1:0] RND  = AW'(64'sd1 <<< (31 - ANGLE_FRAC));
   localparam logic signed [AW-1:0] PI_F = (PI_A + RND) >>> (32 - ANGLE_FRAC);

   assign busy = 1'b0;

   // input register
   logic                       a_valid_ff;
   logic signed [IN_WIDTH-1:0] a_x_ff, a_y_ff, a_z_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         a_valid_ff <= 1'b0;
      end else begin
         a_valid_ff <= start;
      end
      a_x_ff <= req_vec_x;
      a_y_ff <= req_vec_y;
      a_z_ff <= req_vec_z;
   end

   // gain multiply and first pre-rotation
   logic                 b_valid_ff;
   logic signed [PW-1:0] b_prod_ff, b_prod_in;
   c2ea_pkg::cord_type   b_c_ff, b_c_in;
   logic                 b_xyz_ff, b_xyz_in;
   logic                 b_zero_ff, b_zero_in;
   logic signed [DW-1:0] sx, sy;

   always_comb begin
      sx = DW'($signed({a_x_ff, {SH{1'b0}}}));
      sy = DW'($signed({a_y_ff, {SH{1'b0}}}));
      b_prod_in = PW'(a_z_ff) * PW'(c2ea_pkg::GAIN_Q30);
      b_xyz_in = (a_x_ff == '0) && (a_y_ff == '0);
      b_zero_in = b_xyz_in && (a_z_ff == '0);
      if (sx < 0) begin
         b_c_in.x = -sx;
         b_c_in.y = -sy;
         b_c_in.a = (sy >= 0) ? PI_A : -PI_A;
      end else begin
         b_c_in.x = sx;
         b_c_in.y = sy;
         b_c_in.a = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         b_valid_ff <= 1'b0;
      end else begin
         b_valid_ff <= a_valid_ff;
      end
      b_prod_ff <= b_prod_in;
      b_c_ff    <= b_c_in;
      b_xyz_ff  <= b_xyz_in;
      b_zero_ff <= b_zero_in;
   end

   // z scaled by the cordic gain
   logic signed [63:0] zk_wide;
   generate
      if (SH >= 30) begin : g_zk_left
         assign zk_wide = 64'(b_prod_ff) <<< (SH - 30);
      end else begin : g_zk_right
         assign zk_wide = (64'(b_prod_ff) + (64'sd1 <<< (29 - SH))) >>> (30 - SH);
      end
   endgenerate

   // first cordic chain: azimuth and length of (x, y)
   logic                 c_valid_ff [N];
   c2ea_pkg::cord_type   c_c_ff     [N];
   logic signed [DW-1:0] c_zk_ff    [N];
   logic                 c_xyz_ff   [N];
   logic                 c_zero_ff  [N];

   genvar gi;
   generate
      for (gi = 0; gi < N; gi++) begin : g_c1
         c2ea_pkg::cord_type c_c_in;
         if (gi == 0) begin : g_first
            assign c_c_in = c2ea_pkg::cordic_step(b_c_ff, gi);
            always_ff @(posedge clock) begin
               if (reset) begin
                  c_valid_ff[gi] <= 1'b0;
               end else begin
                  c_valid_ff[gi] <= b_valid_ff;
               end
               c_c_ff[gi]    <= c_c_in;
               c_zk_ff[gi]   <= zk_wide[DW-1:0];
               c_xyz_ff[gi]  <= b_xyz_ff;
               c_zero_ff[gi] <= b_zero_ff;
            end
         end else begin : g_next
            assign c_c_in = c2ea_pkg::cordic_step(c_c_ff[gi-1], gi);
            always_ff @(posedge clock) begin
               if (reset) begin
                  c_valid_ff[gi] <= 1'b0;
               end else begin
                  c_valid_ff[gi] <= c_valid_ff[gi-1];
               end
               c_c_ff[gi]    <= c_c_in;
               c_zk_ff[gi]   <= c_zk_ff[gi-1];
               c_xyz_ff[gi]  <= c_xyz_ff[gi-1];
               c_zero_ff[gi] <= c_zero_ff[gi-1];
            end
         end
      end
   endgenerate

   // second pre-rotation on (zk, rho)
   logic                 d_valid_ff;
   c2ea_pkg::cord_type   d_c_ff, d_c_in;
   logic signed [AW-1:0] d_az_ff, d_az_in;
   logic                 d_zero_ff;
   logic signed [DW-1:0] zk_l, rho_l;

   always_comb begin
      zk_l  = c_zk_ff[N-1];
      rho_l = c_c_ff[N-1].x;
      d_az_in = c_xyz_ff[N-1] ? '0 : c_c_ff[N-1].a;
      if (zk_l < 0) begin
         d_c_in.x = -zk_l;
         d_c_in.y = -rho_l;
         d_c_in.a = (rho_l >= 0) ? PI_A : -PI_A;
      end else begin
         d_c_in.x = zk_l;
         d_c_in.y = c_xyz_ff[N-1] ? '0 : rho_l;
         d_c_in.a = '0;
      end
      if (c_xyz_ff[N-1] && zk_l < 0) begin
         d_c_in.y = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         d_valid_ff <= 1'b0;
      end else begin
         d_valid_ff <= c_valid_ff[N-1];
      end
      d_c_ff    <= d_c_in;
      d_az_ff   <= d_az_in;
      d_zero_ff <= c_zero_ff[N-1];
   end

   // second cordic chain: polar angle
   logic                 e_valid_ff [N];
   c2ea_pkg::cord_type   e_c_ff     [N];
   logic signed [AW-1:0] e_az_ff    [N];
   logic                 e_zero_ff  [N];

   generate
      for (gi = 0; gi < N; gi++) begin : g_c2
         c2ea_pkg::cord_type e_c_in;
         if (gi == 0) begin : g_first
            assign e_c_in = c2ea_pkg::cordic_step(d_c_ff, gi);
            always_ff @(posedge clock) begin
               if (reset) begin
                  e_valid_ff[gi] <= 1'b0;
               end else begin
                  e_valid_ff[gi] <= d_valid_ff;
               end
               e_c_ff[gi]    <= e_c_in;
               e_az_ff[gi]   <= d_az_ff;
               e_zero_ff[gi] <= d_zero_ff;
            end
         end else begin : g_next
            assign e_c_in = c2ea_pkg::cordic_step(e_c_ff[gi-1], gi);
            always_ff @(posedge clock) begin
               if (reset) begin
                  e_valid_ff[gi] <= 1'b0;
               end else begin
                  e_valid_ff[gi] <= e_valid_ff[gi-1];
               end
               e_c_ff[gi]    <= e_c_in;
               e_az_ff[gi]   <= e_az_ff[gi-1];
               e_zero_ff[gi] <= e_zero_ff[gi-1];
            end
         end
      end
   endgenerate

   // rounding, saturation and result register
   logic                        o_valid_ff;
   logic signed [ANGLE_FRAC+2:0] o_az_ff, o_az_in;
   logic        [ANGLE_FRAC+1:0] o_pol_ff, o_pol_in;
   logic                        o_inv_ff;
   logic signed [AW-1:0]        ra, rp;

   always_comb begin
      ra = (e_az_ff[N-1] + RND) >>> (32 - ANGLE_FRAC);
      rp = (e_c_ff[N-1].a + RND) >>> (32 - ANGLE_FRAC);
      if (ra > PI_F) begin
         ra = PI_F;
      end
      if (ra < -PI_F) begin
         ra = -PI_F;
      end
      if (rp > PI_F) begin
         rp = PI_F;
      end
      if (rp < 0) begin
         rp = '0;
      end
      if (e_zero_ff[N-1]) begin
         o_az_in  = '0;
         o_pol_in = '0;
      end else begin
         o_az_in  = ra[ANGLE_FRAC+2:0];
         o_pol_in = rp[ANGLE_FRAC+1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         o_valid_ff <= 1'b0;
      end else begin
         o_valid_ff <= e_valid_ff[N-1];
      end
      o_az_ff  <= o_az_in;
      o_pol_ff <= o_pol_in;
      o_inv_ff <= e_zero_ff[N-1];
   end

   assign rsp_valid   = o_valid_ff;
   assign rsp_azimuth = o_az_ff;
   assign rsp_polar   = o_pol_ff;
   assign rsp_invalid = o_inv_ff;

`ifndef SYNTHESIS
   a_latency: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $past(start, LAT))
      else $error("result without matching transfer");
   a_start_out: assert property (@(posedge clock) disable iff (reset)
      start |-> ##LAT rsp_valid)
      else $error("transfer lost in pipeline");
   a_inv_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_invalid) |-> (rsp_azimuth == '0 && rsp_polar == '0))
      else $error("invalid result with nonzero angles");
   a_pol_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> ($signed({1'b0, rsp_polar}) <= PI_F))
      else $error("polar angle out of range");
`endif

endmodule

[tb/cartesian_to_euler_angles_tb.sv]
// testbench for the cartesian vector to azimuth and polar angle block
module cartesian_to_euler_angles_tb;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int IN_W  = 24;
   localparam int FRAC  = 16;
   localparam int STEPS = 18;
   localparam int LATENCY = 2 * STEPS + 4;

   typedef struct {
      logic signed [FRAC+2:0] azimuth;
      logic        [FRAC+1:0] polar;
      logic                   invalid;
   } angles_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic start = 1'b0;
   logic busy;
   logic signed [IN_W-1:0] req_vec_x = '0;
   logic signed [IN_W-1:0] req_vec_y = '0;
   logic signed [IN_W-1:0] req_vec_z = '0;
   logic rsp_valid;
   logic signed [FRAC+2:0] rsp_azimuth;
   logic        [FRAC+1:0] rsp_polar;
   logic rsp_invalid;

   angles_type pending_angles[$];
   int errors = 0;
   int sent = 0;
   int received = 0;
   int zero_vectors = 0;

   cartesian_to_euler_angles i_dut (
      .clock(clock), .reset(reset), .start(start), .busy(busy),
      .req_vec_x(req_vec_x), .req_vec_y(req_vec_y), .req_vec_z(req_vec_z),
      .rsp_valid(rsp_valid), .rsp_azimuth(rsp_azimuth), .rsp_polar(rsp_polar),
      .rsp_invalid(rsp_invalid)
   );

   initial begin
      forever #1 clock = ~clock;
   end

   function automatic logic signed [63:0] atan_of_step(input int i);
      if (i < 11) begin
         return c2ea_pkg::ATAN_TAB[i];
      end
      return 64'sd1 <<< (32 - i);
   endfunction

   function automatic logic signed [63:0] vector_angle(input logic signed [63:0] px_in,
                                                       input logic signed [63:0] py_in,
                                                       output logic signed [63:0] mag);
      logic signed [63:0] px;
      logic signed [63:0] py;
      logic signed [63:0] ang;
      logic signed [63:0] dx;
      logic signed [63:0] dy;
      px = px_in;
      py = py_in;
      ang = 0;
      if (px < 0) begin
         ang = (py >= 0) ? c2ea_pkg::PI_Q32 : -c2ea_pkg::PI_Q32;
         px = -px;
         py = -py;
      end
      for (int i = 0; i < STEPS; i++) begin
         dx = py >>> i;
         dy = px >>> i;
         if (py >= 0) begin
            px = px + dx;
            py = py - dy;
            ang = ang + atan_of_step(i);
         end else begin
            px = px - dx;
            py = py + dy;
            ang = ang - atan_of_step(i);
         end
      end
      mag = px;
      return ang;
   endfunction

   function automatic logic signed [63:0] round_angle(input logic signed [63:0] q32);
      return (q32 + (64'sd1 <<< (31 - FRAC))) >>> (32 - FRAC);
   endfunction

   function automatic angles_type predict_angles(input logic signed [IN_W-1:0] vx,
                                                 input logic signed [IN_W-1:0] vy,
                                                 input logic signed [IN_W-1:0] vz);
      angles_type r;
      logic signed [63:0] x;
      logic signed [63:0] y;
      logic signed [63:0] z;
      logic signed [63:0] az;
      logic signed [63:0] rho;
      logic signed [63:0] zk;
      logic signed [63:0] pol;
      logic signed [63:0] unused;
      logic signed [63:0] pi_f;
      logic signed [63:0] a;
      logic signed [63:0] p;
      x = vx;
      y = vy;
      z = vz;
      az = 0;
      rho = 0;
      r.azimuth = '0;
      r.polar = '0;
      r.invalid = 1'b1;
      if (x == 0 && y == 0 && z == 0) begin
         return r;
      end
      r.invalid = 1'b0;
      if (!(x == 0 && y == 0)) begin
         az = vector_angle(x <<< (56 - IN_W), y <<< (56 - IN_W), rho);
      end
      zk = (z * 64'(c2ea_pkg::GAIN_Q30)) <<< (56 - IN_W - 30);
      pol = vector_angle(zk, rho, unused);
      pi_f = round_angle(c2ea_pkg::PI_Q32);
      a = round_angle(az);
      if (a > pi_f) a = pi_f;
      if (a < -pi_f) a = -pi_f;
      p = round_angle(pol);
      if (p > pi_f) p = pi_f;
      if (p < 0) p = 0;
      r.azimuth = a[FRAC+2:0];
      r.polar = p[FRAC+1:0];
      return r;
   endfunction

   always @(posedge clock) begin
      angles_type e;
      if (!reset && rsp_valid) begin
         received++;
         if (pending_angles.size() == 0) begin
            $error("result with no transfer outstanding");
            errors++;
         end else begin
            e = pending_angles.pop_front();
            if (rsp_azimuth !== e.azimuth) begin
               $error("azimuth expected %0d got %0d", e.azimuth, rsp_azimuth);
               errors++;
            end
            if (rsp_polar !== e.polar) begin
               $error("polar expected %0d got %0d", e.polar, rsp_polar);
               errors++;
            end
            if (rsp_invalid !== e.invalid) begin
               $error("invalid expected %0b got %0b", e.invalid, rsp_invalid);
               errors++;
            end
         end
      end
   end

   task automatic send_vector(input logic signed [IN_W-1:0] vx,
                              input logic signed [IN_W-1:0] vy,
                              input logic signed [IN_W-1:0] vz);
      int gap;
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 14);
      if (gap > 0) begin
         start <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      start <= 1'b1;
      req_vec_x <= vx;
      req_vec_y <= vy;
      req_vec_z <= vz;
      @(negedge clock);
      while (busy) @(negedge clock);
      @(posedge clock);
      pending_angles.push_back(predict_angles(vx, vy, vz));
      sent++;
      if (vx == 0 && vy == 0 && vz == 0) zero_vectors++;
   endtask

   function automatic logic signed [IN_W-1:0] random_component();
      case ($urandom_range(0, 5))
         0: return '0;
         1: return IN_W'($signed($urandom_range(0, 32)) - 16);
         2: return {1'b0, {(IN_W-1){1'b1}}};
         3: return {1'b1, {(IN_W-1){1'b0}}};
         default: return IN_W'($urandom);
      endcase
   endfunction

   task automatic test_special_vectors();
      localparam logic signed [IN_W-1:0] MAXV = {1'b0, {(IN_W-1){1'b1}}};
      localparam logic signed [IN_W-1:0] MINV = {1'b1, {(IN_W-1){1'b0}}};
      send_vector(0, 0, 0);
      send_vector(0, 0, 1);
      send_vector(0, 0, -1);
      send_vector(0, 0, MAXV);
      send_vector(0, 0, MINV);
      send_vector(1, 0, 0);
      send_vector(-1, 0, 0);
      send_vector(0, 1, 0);
      send_vector(0, -1, 0);
      send_vector(MINV, 0, 5);
      send_vector(MINV, -1, 5);
      send_vector(MAXV, MAXV, MAXV);
      send_vector(MINV, MINV, MINV);
      send_vector(MAXV, MINV, 0);
      send_vector(MINV, MAXV, MAXV);
      send_vector(-1, -1, -1);
      send_vector(1, 1, 1);
      send_vector(-5, 3, 0);
      send_vector(MAXV, 1, MINV);
      send_vector(-7, -1, 0);
   endtask

   task automatic test_random_vectors(input int count);
      for (int n = 0; n < count; n++) begin
         send_vector(random_component(), random_component(), random_component());
      end
   endtask

   task automatic drain_results();
      int waited;
      waited = 0;
      start <= 1'b0;
      while (pending_angles.size() != 0 && waited < 10000) begin
         @(posedge clock);
         waited++;
      end
      repeat (LATENCY + 8) @(posedge clock);
   endtask

   initial begin
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_special_vectors();
      test_random_vectors(1000);
      drain_results();
      if (pending_angles.size() != 0) begin
         $error("%0d results never arrived", pending_angles.size());
         errors++;
      end
      $display("%0d vectors sent, %0d zero vectors, %0d results checked",
               sent, zero_vectors, received);
      if (errors == 0) begin
         $display("cartesian_to_euler_angles regression: pass");
      end else begin
         $display("cartesian_to_euler_angles regression: fail");
      end
      $finish;
   end

   initial begin
      #2ms;
      $display("cartesian_to_euler_angles regression: fail");
      $finish;
   end
endmodule
